>>> rtl/core/scq_pkg.sv
package scq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DUP   = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_PUT,
    S_POP_RD,
    S_POP_WR,
    S_TCK_RD,
    S_TCK_WR,
    S_FIN
  } state_t;

endpackage

>>> rtl/core/sorted_countdown_queue_core.sv
// Sorted key queue with insert, pop-smallest and tick (decrement all, saturating).
// An item is taken when start is high and busy is low; busy then stays high until
// the cycle in which done strobes the single result, and the receiver cannot stall.
// Keys live in one memory with a registered read and a separate write port, walked
// one entry per read state and compare or write state. Insert appends at the tail,
// stops on a duplicate, or shifts the larger keys up from the tail and then writes
// the key; pop copies each entry one place down; tick writes each back decremented.
// Each operation ends in S_FIN, which strobes the result. Full, empty, single-entry
// pop and unused-code items strobe their result in the cycle right after the accept.
module sorted_countdown_queue_core #(
  parameter int CAPACITY = scq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = scq_pkg::DEF_KEY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [15:0] key,
  output logic               done,
  output logic [1:0]         status,
  output logic               head_valid,
  output logic signed [15:0] head_key,
  output logic [4:0]         occupancy
);

  import scq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_BITS > 16) ? KEY_BITS : 16;
  localparam int OW = (CW > 5) ? CW : 5;
  localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rdata;

  state_t              state, state_next;
  logic [1:0]          op;
  logic [KEY_BITS-1:0] kreg;
  logic [AW-1:0]       ptr, ptr_next;
  logic [AW-1:0]       pos, pos_next;
  logic [CW-1:0]       count, count_next;
  logic [KEY_BITS-1:0] head, head_next;
  logic [1:0]          status_reg, status_next;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;

  logic                accept;
  logic [KW-1:0]       key_ext;
  logic [KEY_BITS-1:0] key_in;
  logic                ptr_last;
  logic                is_full;
  logic                is_empty;
  logic [KW-1:0]       head_ext;
  logic [OW-1:0]       occ_ext;

  assign accept   = start && (state == S_IDLE);
  assign key_ext  = KW'($unsigned(key));
  assign key_in   = key_ext[KEY_BITS-1:0];
  assign ptr_last = ((CW'(ptr) + CW'(1)) == count);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (func == FUNC_INSERT) begin
            state_next = (is_full || is_empty) ? S_FIN : S_INS_RD;
          end else if (func == FUNC_POP) begin
            state_next = (count > CW'(1)) ? S_POP_RD : S_FIN;
          end else if (func == FUNC_TICK) begin
            state_next = is_empty ? S_FIN : S_TCK_RD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_INS_RD: state_next = S_INS_CMP;
      S_INS_CMP: begin
        priority if ($signed(rdata) < $signed(kreg)) begin
          state_next = ptr_last ? S_FIN : S_INS_RD;
        end else if (rdata == kreg) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SHF_RD;
        end
      end
      S_SHF_RD: state_next = S_SHF_WR;
      S_SHF_WR: state_next = (ptr == pos) ? S_INS_PUT : S_SHF_RD;
      S_INS_PUT: state_next = S_FIN;
      S_POP_RD: state_next = S_POP_WR;
      S_POP_WR: state_next = ptr_last ? S_FIN : S_POP_RD;
      S_TCK_RD: state_next = S_TCK_WR;
      S_TCK_WR: state_next = ptr_last ? S_FIN : S_TCK_RD;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ptr_next    = ptr;
    pos_next    = pos;
    count_next  = count;
    status_next = status_reg;
    we          = 1'b0;
    waddr       = ptr;
    wdata       = rdata;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = STATUS_OK;
          ptr_next    = '0;
          priority if (func == FUNC_INSERT) begin
            priority if (is_full) begin
              status_next = STATUS_FULL;
            end else if (is_empty) begin
              we         = 1'b1;
              waddr      = '0;
              wdata      = key_in;
              count_next = CW'(1);
            end else begin
              ptr_next = '0;
            end
          end else if (func == FUNC_POP) begin
            priority if (is_empty) begin
              status_next = STATUS_EMPTY;
            end else if (count == CW'(1)) begin
              count_next = '0;
            end else begin
              ptr_next = AW'(1);
            end
          end else begin
            ptr_next = '0;
          end
        end
      end
      S_INS_CMP: begin
        priority if ($signed(rdata) < $signed(kreg)) begin
          if (ptr_last) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = kreg;
            count_next = count + CW'(1);
          end else begin
            ptr_next = ptr + AW'(1);
          end
        end else if (rdata == kreg) begin
          status_next = STATUS_DUP;
        end else begin
          pos_next = ptr;
          ptr_next = AW'(count - CW'(1));
        end
      end
      S_SHF_WR: begin
        we    = 1'b1;
        waddr = ptr + AW'(1);
        wdata = rdata;
        if (ptr != pos) begin
          ptr_next = ptr - AW'(1);
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = kreg;
        count_next = count + CW'(1);
      end
      S_POP_WR: begin
        we    = 1'b1;
        waddr = ptr - AW'(1);
        wdata = rdata;
        if (ptr_last) begin
          count_next = count - CW'(1);
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      S_TCK_WR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = (rdata == KEY_MIN) ? rdata : rdata - KEY_BITS'(1);
        if (!ptr_last) begin
          ptr_next = ptr + AW'(1);
        end
      end
      default: begin
      end
    endcase
    head_next = (we && waddr == '0) ? wdata : head;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= func;
      kreg <= key_in;
    end
    ptr        <= ptr_next;
    pos        <= pos_next;
    head       <= head_next;
    status_reg <= status_next;
  end

  assign head_ext   = KW'($signed(head));
  assign occ_ext    = OW'(count);
  assign busy       = (state != S_IDLE);
  assign done       = (state == S_FIN);
  assign status     = (op == FUNC_TICK) ? STATUS_OK : status_reg;
  assign head_valid = !is_empty;
  assign head_key   = is_empty ? 16'sd0 : $signed(head_ext[15:0]);
  assign occupancy  = occ_ext[4:0];

endmodule
